// ===== design/mp2d_pkg.sv =====
// package for the 2-d max pooling block: sizes, widths and geometry helpers
// no dependencies
`timescale 1ns / 1ps
package mp2d_pkg;
    localparam int MAX_HEIGHT  = 64;
    localparam int MAX_WIDTH   = 64;
    localparam int MAX_KERNEL  = 8;
    localparam int SAMPLE_BITS = 16;
    localparam int OUT_LIMIT   = 64;
    localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int ADDR_BITS   = ROW_BITS + COL_BITS;
    localparam int DIM_BITS    = 7;
    localparam int KER_BITS    = 4;
    localparam int PAD_BITS    = 3;
    localparam int IDX_BITS    = 3;

    localparam logic [IDX_BITS-1:0] REG_IN_HEIGHT = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_IN_WIDTH  = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_KERNEL_H  = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_KERNEL_W  = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_STEP      = 3'd4;
    localparam logic [IDX_BITS-1:0] REG_PAD       = 3'd5;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
endpackage

// ===== design/max_pool_2d_with_argmax.sv =====
// max pooling with argmax over one plane fed in raster order
// depends on mp2d_pkg; holds the plane store memory and the window scan sequencer
//
// channel   direction  handshake             payload
// in        into block in_valid / in_stall    sample, plane
// out       from block out_valid / out_stall  max_value .. last
// cfg       into block cfg_valid / cfg_ready  cfg_index, cfg_data
//
// an item is taken and written to the plane store; the sequencer then sweeps the
// output rows one per cycle, and for a row that ends at this pixel the output
// columns one per cycle, holding while a finished window waits on a full output
// register; each window that ends here adds one store read per real position and a
// wait for the last read to return; then the final result is handed over
// the single read port of the plane store sets the scan rate
// a configuration error result is written straight into the output register; after
// a register write the input stalls while the geometry settles
// a finished window waits in its own register and the scan holds while the output
// register is kept full by out_stall
// reset is asynchronous; the plane store is not cleared
`timescale 1ns / 1ps
module max_pool_2d_with_argmax (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [mp2d_pkg::SAMPLE_BITS-1:0] sample,
    input  logic [15:0]                          plane,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [mp2d_pkg::SAMPLE_BITS-1:0] max_value,
    output logic [5:0]                           out_row,
    output logic [5:0]                           out_col,
    output logic [5:0]                           win_row,
    output logic [5:0]                           win_col,
    output logic [15:0]                          plane_out,
    output logic                                 config_error,
    output logic                                 last,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mp2d_pkg::IDX_BITS-1:0]        cfg_index,
    input  logic [15:0]                          cfg_data
);
    import mp2d_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_OROW, S_OCOL, S_SCAN, S_DRAIN, S_EMIT
    } state_t;

    // configuration
    logic [DIM_BITS-1:0] in_height_reg, in_width_reg;
    logic [KER_BITS-1:0] kernel_h_reg, kernel_w_reg, step_reg;
    logic [PAD_BITS-1:0] pad_reg;

    // geometry, registered once the register writes stop
    logic       geo_ok_reg;
    logic [6:0] oh_n_reg, ow_n_reg;
    logic       geo_dirty_reg;

    logic [ROW_BITS-1:0] pix_row_reg;
    logic [COL_BITS-1:0] pix_col_reg;

    // plane store
    sample_t             store_mem [MAX_HEIGHT*MAX_WIDTH];
    sample_t             rd_data_reg;
    logic [ADDR_BITS-1:0] rd_addr;
    logic                rd_en;

    state_t         state_reg;
    logic [15:0]    plane_reg;
    logic [ROW_BITS-1:0] r_reg;
    logic [COL_BITS-1:0] c_reg;
    logic [6:0]     oh_reg, ow_reg;
    logic [ROW_BITS-1:0] i_reg, i0_reg;
    logic [COL_BITS-1:0] j_reg, j0_reg;
    logic           pend_reg;         // a read is in flight
    logic [ROW_BITS-1:0] pi_reg;
    logic [COL_BITS-1:0] pj_reg;
    logic           found_reg;
    sample_t        best_reg;
    logic [ROW_BITS-1:0] br_reg;
    logic [COL_BITS-1:0] bc_reg;
    logic           have_res_reg;     // a finished window waits for its last flag

    // finished window, kept apart from the output register
    sample_t        res_value_reg;
    logic [5:0]     res_orow_reg, res_ocol_reg, res_wrow_reg, res_wcol_reg;

    // output register
    logic           out_valid_reg;
    sample_t        max_value_reg;
    logic [5:0]     out_row_reg, out_col_reg, win_row_reg, win_col_reg;
    logic [15:0]    plane_out_reg;
    logic           cfg_err_reg, last_reg;

    logic           in_acc, out_free;
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE) || geo_dirty_reg || !out_free;
    assign in_acc    = in_valid && !in_stall;
    assign cfg_ready = (state_reg == S_IDLE) && !in_valid;

    // geometry helpers, padded sizes fit in 8 bits
    logic [7:0] ph, pw;
    logic [7:0] dh, dw;
    logic [6:0] qh, qw;
    logic       geo_ok;
    assign ph = 8'(in_height_reg) + 8'({pad_reg, 1'b0});
    assign pw = 8'(in_width_reg) + 8'({pad_reg, 1'b0});
    assign dh = ph - 8'(kernel_h_reg);
    assign dw = pw - 8'(kernel_w_reg);

    // loop-free division: strides 1 to 8 by shift or multiply, any other gives 0
    function automatic logic [6:0] div_step(input logic [7:0] n, input logic [3:0] d);
        logic [7:0] q;
        q = 8'd0;
        case (d)
            4'd1: q = n;
            4'd2: q = n >> 1;
            4'd3: q = 8'((16'(n) * 16'd171) >> 9);
            4'd4: q = n >> 2;
            4'd5: q = 8'((16'(n) * 16'd205) >> 10);
            4'd6: q = 8'((16'(n) * 16'd171) >> 10);
            4'd7: q = 8'((16'(n) * 16'd147) >> 10);
            4'd8: q = n >> 3;
            default: q = 8'd0;
        endcase
        return 7'(q);
    endfunction

    assign qh = div_step(dh, step_reg);
    assign qw = div_step(dw, step_reg);
    assign geo_ok = (in_height_reg != 0) && (in_height_reg <= DIM_BITS'(MAX_HEIGHT))
        && (in_width_reg != 0) && (in_width_reg <= DIM_BITS'(MAX_WIDTH))
        && (kernel_h_reg != 0) && (kernel_w_reg != 0) && (step_reg != 0)
        && (kernel_h_reg <= KER_BITS'(MAX_KERNEL)) && (kernel_w_reg <= KER_BITS'(MAX_KERNEL))
        && (4'(pad_reg) < kernel_h_reg) && (4'(pad_reg) < kernel_w_reg)
        && (8'(kernel_h_reg) <= ph) && (8'(kernel_w_reg) <= pw)
        && (qh < 7'(OUT_LIMIT)) && (qw < 7'(OUT_LIMIT));

    // last and first real indices for window o on each axis
    logic [10:0] end_h, end_w, st_h, st_w;
    logic [ROW_BITS-1:0] last_h, first_h;
    logic [COL_BITS-1:0] last_w, first_w;
    assign end_h = 11'(oh_reg) * 11'(step_reg) + 11'(kernel_h_reg) - 11'd1 - 11'(pad_reg);
    assign end_w = 11'(ow_reg) * 11'(step_reg) + 11'(kernel_w_reg) - 11'd1 - 11'(pad_reg);
    assign st_h  = 11'(oh_reg) * 11'(step_reg);
    assign st_w  = 11'(ow_reg) * 11'(step_reg);
    assign last_h  = (end_h < 11'(in_height_reg) - 11'd1) ? ROW_BITS'(end_h)
                                                          : ROW_BITS'(in_height_reg - 7'd1);
    assign last_w  = (end_w < 11'(in_width_reg) - 11'd1) ? COL_BITS'(end_w)
                                                         : COL_BITS'(in_width_reg - 7'd1);
    assign first_h = (st_h > 11'(pad_reg)) ? ROW_BITS'(st_h - 11'(pad_reg)) : '0;
    assign first_w = (st_w > 11'(pad_reg)) ? COL_BITS'(st_w - 11'(pad_reg)) : '0;

    // a new item enters the output register this cycle
    logic out_set;
    assign out_set = ((state_reg == S_IDLE) && in_acc && !geo_ok_reg)
        || ((state_reg == S_OCOL) && (ow_reg < ow_n_reg) && (last_w == c_reg)
            && have_res_reg && out_free)
        || ((state_reg == S_EMIT) && have_res_reg && out_free);

    assign rd_en   = (state_reg == S_SCAN);
    assign rd_addr = {i_reg, j_reg};

    // plane store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (in_acc && geo_ok_reg)
        begin
            store_mem[{(pix_row_reg), (pix_col_reg)}] <= sample;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    // compare of the read word against the running best
    logic take;
    assign take = !found_reg || (rd_data_reg > best_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_height_reg <= 7'd4;
            in_width_reg  <= 7'd4;
            kernel_h_reg  <= 4'd2;
            kernel_w_reg  <= 4'd2;
            step_reg      <= 4'd2;
            pad_reg       <= 3'd0;
            geo_ok_reg    <= 1'b1;
            oh_n_reg      <= 7'd2;
            ow_n_reg      <= 7'd2;
            geo_dirty_reg <= 1'b0;
            pix_row_reg   <= '0;
            pix_col_reg   <= '0;
            state_reg     <= S_IDLE;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            have_res_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_set)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_IN_HEIGHT: in_height_reg <= cfg_data[6:0];
                    REG_IN_WIDTH:  in_width_reg  <= cfg_data[6:0];
                    REG_KERNEL_H:  kernel_h_reg  <= cfg_data[3:0];
                    REG_KERNEL_W:  kernel_w_reg  <= cfg_data[3:0];
                    REG_STEP:      step_reg      <= cfg_data[3:0];
                    REG_PAD:       pad_reg       <= cfg_data[2:0];
                    default: ;
                endcase
                if (cfg_index <= REG_PAD)
                begin
                    pix_row_reg   <= '0;
                    pix_col_reg   <= '0;
                    geo_dirty_reg <= 1'b1;
                end
            end
            else if (geo_dirty_reg)
            begin
                // geometry is registered from the new values once the writes stop
                geo_ok_reg    <= geo_ok;
                oh_n_reg      <= qh + 7'd1;
                ow_n_reg      <= qw + 7'd1;
                geo_dirty_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (!geo_ok_reg)
                        begin
                            max_value_reg <= '0;
                            out_row_reg   <= '0;
                            out_col_reg   <= '0;
                            win_row_reg   <= '0;
                            win_col_reg   <= '0;
                            plane_out_reg <= '0;
                            cfg_err_reg   <= 1'b1;
                            last_reg      <= 1'b0;
                        end
                        else
                        begin
                            r_reg     <= pix_row_reg;
                            c_reg     <= pix_col_reg;
                            plane_reg <= plane;
                            oh_reg    <= '0;
                            have_res_reg <= 1'b0;
                            state_reg <= S_OROW;
                            if (7'(pix_col_reg) + 7'd1 >= in_width_reg)
                            begin
                                pix_col_reg <= '0;
                                pix_row_reg <= (7'(pix_row_reg) + 7'd1 >= in_height_reg)
                                    ? '0 : pix_row_reg + 1'b1;
                            end
                            else
                            begin
                                pix_col_reg <= pix_col_reg + 1'b1;
                            end
                        end
                    end
                end
                S_OROW:
                begin
                    // find output rows whose last real row is this pixel's row
                    if (oh_reg >= oh_n_reg)
                    begin
                        state_reg <= S_EMIT;
                    end
                    else if (last_h == r_reg)
                    begin
                        ow_reg    <= '0;
                        i0_reg    <= first_h;
                        state_reg <= S_OCOL;
                    end
                    else
                    begin
                        oh_reg <= oh_reg + 7'd1;
                    end
                end
                S_OCOL:
                begin
                    if (ow_reg >= ow_n_reg)
                    begin
                        oh_reg    <= oh_reg + 7'd1;
                        state_reg <= S_OROW;
                    end
                    else if (last_w == c_reg)
                    begin
                        // a window ends here: the previous one can leave now
                        if (!have_res_reg || out_free)
                        begin
                            if (have_res_reg)
                            begin
                                max_value_reg <= res_value_reg;
                                out_row_reg   <= res_orow_reg;
                                out_col_reg   <= res_ocol_reg;
                                win_row_reg   <= res_wrow_reg;
                                win_col_reg   <= res_wcol_reg;
                                plane_out_reg <= plane_reg;
                                cfg_err_reg   <= 1'b0;
                                last_reg      <= 1'b0;
                                have_res_reg  <= 1'b0;
                            end
                            j0_reg    <= first_w;
                            i_reg     <= i0_reg;
                            j_reg     <= first_w;
                            found_reg <= 1'b0;
                            pend_reg  <= 1'b0;
                            state_reg <= S_SCAN;
                        end
                    end
                    else
                    begin
                        ow_reg <= ow_reg + 7'd1;
                    end
                end
                S_SCAN:
                begin
                    // one store read per cycle over the real window positions
                    pend_reg <= 1'b1;
                    pi_reg   <= i_reg;
                    pj_reg   <= j_reg;
                    if (pend_reg && take)
                    begin
                        best_reg  <= rd_data_reg;
                        br_reg    <= pi_reg;
                        bc_reg    <= pj_reg;
                        found_reg <= 1'b1;
                    end
                    if (j_reg == c_reg)
                    begin
                        j_reg <= j0_reg;
                        if (i_reg == r_reg)
                        begin
                            state_reg <= S_DRAIN;
                        end
                        else
                        begin
                            i_reg <= i_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
                S_DRAIN:
                begin
                    // last read comes back; result is held until the next window or the end
                    pend_reg      <= 1'b0;
                    res_value_reg <= take ? rd_data_reg : best_reg;
                    res_wrow_reg  <= 6'(take ? pi_reg : br_reg);
                    res_wcol_reg  <= 6'(take ? pj_reg : bc_reg);
                    res_orow_reg  <= 6'(oh_reg);
                    res_ocol_reg  <= 6'(ow_reg);
                    have_res_reg  <= 1'b1;
                    ow_reg        <= ow_reg + 7'd1;
                    state_reg     <= S_OCOL;
                end
                S_EMIT:
                begin
                    if (!have_res_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (out_free)
                    begin
                        max_value_reg <= res_value_reg;
                        out_row_reg   <= res_orow_reg;
                        out_col_reg   <= res_ocol_reg;
                        win_row_reg   <= res_wrow_reg;
                        win_col_reg   <= res_wcol_reg;
                        plane_out_reg <= plane_reg;
                        cfg_err_reg   <= 1'b0;
                        last_reg      <= 1'b1;
                        have_res_reg  <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign max_value    = max_value_reg;
    assign out_row      = out_row_reg;
    assign out_col      = out_col_reg;
    assign win_row      = win_row_reg;
    assign win_col      = win_col_reg;
    assign plane_out    = plane_out_reg;
    assign config_error = cfg_err_reg;
    assign last         = last_reg;

    // no item is taken while a window scan runs
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_acc)
        else $error("item accepted during scan");
    // the scan stays inside the stored rows
    a_scan_rows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (i_reg <= r_reg))
        else $error("scan row past pixel row");
    // a result with an error flag never carries last
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && config_error) |-> !last)
        else $error("error result flagged last");
endmodule

// ===== tb/tb_top.sv =====
// self-checking bench for max_pool_2d_with_argmax: raster-fed planes, windows checked per field
// depends on mp2d_pkg and the block under test
`timescale 1ns / 1ps
module tb_top;
    import mp2d_pkg::*;

    // one result of the block
    typedef struct packed {
        logic [15:0] value;
        logic [5:0]  orow;
        logic [5:0]  ocol;
        logic [5:0]  wrow;
        logic [5:0]  wcol;
        logic [15:0] pl;
        logic        err;
        logic        fin;
    } pool_res_t;

    // directed row: sample, plane, and an optional typed-in result for the first window
    typedef struct {
        logic [15:0] smp;
        logic [15:0] pl;
        logic        known;
        pool_res_t   res;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [SAMPLE_BITS-1:0] sample = '0;
    logic [15:0] plane = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [SAMPLE_BITS-1:0] max_value;
    logic [5:0] out_row, out_col, win_row, win_col;
    logic [15:0] plane_out;
    logic config_error, last;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [IDX_BITS-1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    max_pool_2d_with_argmax u_top (.*);

    // shadow copy of the block's registers, store and raster position
    int unsigned sh_h, sh_w, sh_kh, sh_kw, sh_step, sh_pad;
    logic [15:0] pix_mem [MAX_HEIGHT*MAX_WIDTH];
    int unsigned cur_row, cur_col;

    pool_res_t expected_windows[$];
    int mismatches = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // valid geometry check, with output sizes
    function automatic bit geometry_ok(output int unsigned oh, output int unsigned ow);
        int unsigned ph, pw;
        oh = 0;
        ow = 0;
        if (sh_h == 0 || sh_h > MAX_HEIGHT || sh_w == 0 || sh_w > MAX_WIDTH) return 1'b0;
        if (sh_kh == 0 || sh_kw == 0 || sh_step == 0) return 1'b0;
        if (sh_kh > MAX_KERNEL || sh_kw > MAX_KERNEL) return 1'b0;
        if (sh_pad >= sh_kh || sh_pad >= sh_kw) return 1'b0;
        ph = sh_h + 2 * sh_pad;
        pw = sh_w + 2 * sh_pad;
        if (sh_kh > ph || sh_kw > pw) return 1'b0;
        oh = (ph - sh_kh) / sh_step + 1;
        ow = (pw - sh_kw) / sh_step + 1;
        return oh <= OUT_LIMIT && ow <= OUT_LIMIT;
    endfunction

    // clipped last / first real input index covered by window o
    function automatic int unsigned window_end(int unsigned o, int unsigned k, int unsigned sz);
        int unsigned e;
        e = o * sh_step + k - 1 - sh_pad;
        return (e < sz - 1) ? e : sz - 1;
    endfunction

    function automatic int unsigned window_start(int unsigned o);
        return (o * sh_step > sh_pad) ? o * sh_step - sh_pad : 0;
    endfunction

    // store one pixel and queue the windows it completes, or an error result on a bad geometry
    task automatic pool_pixel(input logic [15:0] smp, input logic [15:0] pl);
        int unsigned oh_n, ow_n, r, c, n, br, bc;
        logic signed [15:0] best;
        pool_res_t res;
        if (!geometry_ok(oh_n, ow_n))
        begin
            res = '0;
            res.err = 1'b1;
            expected_windows.push_back(res);
            return;
        end
        if (cur_row >= sh_h || cur_col >= sh_w)
        begin
            cur_row = 0;
            cur_col = 0;
        end
        r = cur_row;
        c = cur_col;
        pix_mem[r*MAX_WIDTH + c] = smp;
        n = 0;
        for (int unsigned oh = 0; oh < oh_n; oh++)
        begin
            if (window_end(oh, sh_kh, sh_h) != r) continue;
            for (int unsigned ow = 0; ow < ow_n; ow++)
            begin
                if (window_end(ow, sh_kw, sh_w) != c || n >= 64) continue;
                best = 16'sh8000;
                br = 0;
                bc = 0;
                for (int unsigned i = window_start(oh); i <= r; i++)
                    for (int unsigned j = window_start(ow); j <= c; j++)
                        if ((i == window_start(oh) && j == window_start(ow))
                            || $signed(pix_mem[i*MAX_WIDTH + j]) > best)
                        begin
                            best = pix_mem[i*MAX_WIDTH + j];
                            br = i;
                            bc = j;
                        end
                res = '0;
                res.value = best;
                res.orow = oh[5:0];
                res.ocol = ow[5:0];
                res.wrow = br[5:0];
                res.wcol = bc[5:0];
                res.pl = pl;
                expected_windows.push_back(res);
                n++;
            end
        end
        if (n > 0) expected_windows[expected_windows.size()-1].fin = 1'b1;
        cur_col = c + 1;
        if (cur_col >= sh_w)
        begin
            cur_col = 0;
            cur_row = (r + 1 >= sh_h) ? 0 : r + 1;
        end
    endtask

    // register write, taken once the block is idle and no pixel is offered
    task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [15:0] val);
        if (in_valid) in_valid <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_IN_HEIGHT: sh_h    = 32'(val[6:0]);
            REG_IN_WIDTH:  sh_w    = 32'(val[6:0]);
            REG_KERNEL_H:  sh_kh   = 32'(val[3:0]);
            REG_KERNEL_W:  sh_kw   = 32'(val[3:0]);
            REG_STEP:      sh_step = 32'(val[3:0]);
            REG_PAD:       sh_pad  = 32'(val[2:0]);
            default: return;
        endcase
        cur_row = 0;
        cur_col = 0;
    endtask

    task automatic set_geometry(input int unsigned h, w, kh, kw, st, pd);
        write_reg(REG_IN_HEIGHT, 16'(h));
        write_reg(REG_IN_WIDTH, 16'(w));
        write_reg(REG_KERNEL_H, 16'(kh));
        write_reg(REG_KERNEL_W, 16'(kw));
        write_reg(REG_STEP, 16'(st));
        write_reg(REG_PAD, 16'(pd));
    endtask

    // wait for the block to drain; the sequencer may still sweep after the last result
    task automatic drain();
        if (in_valid) in_valid <= 1'b0;
        if (cfg_valid) cfg_valid <= 1'b0;
        while (expected_windows.size() != 0) @(posedge clk);
        repeat (700) @(posedge clk);
    endtask

    // hand one pixel over, with random idle gaps before it
    task automatic send_pixel(input logic [15:0] smp, input logic [15:0] pl);
        if (cfg_valid) cfg_valid <= 1'b0;
        while ($urandom_range(99) < send_idle_pct)
        begin
            if (in_valid) in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= smp;
        plane    <= pl;
        do @(posedge clk); while (in_stall);
        pool_pixel(smp, pl);
    endtask

    // random sample with bias toward extremes and ties
    function automatic logic [15:0] rand_sample();
        case ($urandom_range(5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'($urandom_range(3));
            default: return 16'($urandom);
        endcase
    endfunction

    // a plane with random content, cut short after cnt_lim pixels
    task automatic send_plane(input int unsigned cnt_lim);
        logic [15:0] pl;
        pl = 16'($urandom);
        for (int unsigned k = 0; k < sh_h * sh_w && k < cnt_lim; k++)
            send_pixel(rand_sample(), pl);
    endtask

    // receiver side: random stall, compare each accepted result
    always @(posedge clk)
    begin
        pool_res_t got, want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got = {max_value, out_row, out_col, win_row, win_col, plane_out,
                       config_error, last};
                if (expected_windows.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h", got);
                end
                else
                begin
                    want = expected_windows.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected val %h orow %0d ocol %0d wrow %0d wcol %0d pl %h err %b last %b, got val %h orow %0d ocol %0d wrow %0d wcol %0d pl %h err %b last %b",
                                want.value, want.orow, want.ocol, want.wrow, want.wcol,
                                want.pl, want.err, want.fin, got.value, got.orow,
                                got.ocol, got.wrow, got.wcol, got.pl, got.err, got.fin);
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // directed table on the reset geometry (4x4, 2x2 stride 2)
    stim_row_t dir_rows[16];

    initial
    begin
        pool_res_t r0;
        int pct_s[4] = '{0, 72, 0, 37};
        int pct_r[4] = '{0, 0, 72, 37};
        sh_h = 4; sh_w = 4; sh_kh = 2; sh_kw = 2; sh_step = 2; sh_pad = 0;
        cur_row = 0;
        cur_col = 0;
        // first window: two positive extremes tie and the earlier one in raster order wins
        foreach (dir_rows[k])
        begin
            dir_rows[k].smp = 16'h8000;
            dir_rows[k].pl = 16'hffff;
            dir_rows[k].known = 1'b0;
        end
        dir_rows[1].smp = 16'h7fff;
        dir_rows[4].smp = 16'h7fff;
        r0 = '0;
        r0.value = 16'h7fff;
        r0.orow = 6'd0; r0.ocol = 6'd0; r0.wrow = 6'd0; r0.wcol = 6'd1;
        r0.pl = 16'hffff;
        r0.fin = 1'b1;
        dir_rows[5].known = 1'b1;
        dir_rows[5].res = r0;
        dir_rows[15].smp = 16'h0000;
        dir_rows[15].pl = 16'h0000;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[k])
        begin
            send_pixel(dir_rows[k].smp, dir_rows[k].pl);
            // typed-in result must agree with the predictor
            if (dir_rows[k].known && expected_windows[expected_windows.size()-1] != dir_rows[k].res)
            begin
                mismatches++;
                $display("predictor disagrees with table row %0d", k);
            end
        end
        drain();

        // an invalid configuration: padding equal to the kernel, then an unknown index
        write_reg(REG_PAD, 16'd2);
        send_pixel(16'h1234, 16'h0001);
        send_pixel(16'h8000, 16'hffff);
        drain();
        write_reg(3'd7, 16'hffff);
        send_pixel(16'h0001, 16'h0002);
        drain();
        // zero height, kernel height and stride, with too large width, kernel width and padding
        set_geometry(0, 65, 0, 9, 0, 7);
        send_pixel(16'h7fff, 16'h0);
        drain();

        // random phases over a spread of geometries, extremes among them
        for (int ph = 0; ph < 8; ph++)
        begin
            send_idle_pct = pct_s[ph % 4];
            recv_stall_pct = pct_r[ph % 4];
            case (ph)
                0: set_geometry(3, 5, 1, 1, 1, 0);
                1: set_geometry(5, 5, 3, 3, 1, 1);
                2: set_geometry(6, 7, 3, 2, 2, 1);
                3: set_geometry(8, 8, 8, 8, 8, 7);
                4: set_geometry(64, 1, 8, 1, 8, 0);
                5: set_geometry(4, 6, 2, 3, 3, 1);
                6: set_geometry(1, 64, 1, 8, 1, 0);
                default: set_geometry(2 + $urandom_range(4), 2 + $urandom_range(4),
                                      1 + $urandom_range(2), 1 + $urandom_range(2),
                                      1 + $urandom_range(2), 0);
            endcase
            send_plane((ph == 4 || ph == 6) ? 40 : ((ph == 5) ? 10 : 64));
            // a broken plane: restart mid-way by rewriting a register
            if (ph == 5)
            begin
                drain();
                write_reg(REG_PAD, 16'(sh_pad));
                send_plane(64);
            end
            drain();
        end
        drain();
        if (mismatches == 0 && expected_windows.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end
endmodule

// ===== sim.f =====
design/mp2d_pkg.sv
design/max_pool_2d_with_argmax.sv
tb/tb_top.sv
